// File: sv/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// shared sizes, command and status codes, and the operation struct passed
// from the pointer unit to the slot memory
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // one command, resolved: slot write, the two end addresses to read, status and new count
    typedef struct packed {
        logic                     wr_en;
        idx_t                     wr_addr;
        logic signed [DATA_W-1:0] wr_data;
        idx_t                     rd_front;
        idx_t                     rd_back;
        logic [STAT_W-1:0]        status;
        cnt_t                     count;
    } deq_op_t;

endpackage

// File: sv/deq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_req_if
// command channel: valid/ready with command code and push value
// ----------------------------------------------------------------------------
interface deq_req_if;

    logic                              valid;
    logic                              ready;
    logic [deq_pkg::CMD_W-1:0]         cmd;
    logic signed [deq_pkg::DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);

endinterface

// File: sv/deq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_rsp_if
// result channel: valid/ready with status, end values and occupancy
// ----------------------------------------------------------------------------
interface deq_rsp_if;

    logic                              valid;
    logic                              ready;
    logic [deq_pkg::STAT_W-1:0]        status;
    logic signed [deq_pkg::DATA_W-1:0] front_value;
    logic signed [deq_pkg::DATA_W-1:0] back_value;
    logic                              is_empty;
    logic [deq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output front_value, output back_value,
                    output is_empty, output occupancy, input ready);
    modport sink   (input valid, input status, input front_value, input back_value,
                    input is_empty, input occupancy, output ready);

endinterface

// File: sv/deq_ptr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ptr
// front index and entry count; resolves a command into a slot write and
// the addresses of the new front and back entries
// ----------------------------------------------------------------------------
module deq_ptr
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [deq_pkg::CMD_W-1:0]         cmd,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    output deq_pkg::deq_op_t                  op
);

    localparam logic [deq_pkg::SUM_W-1:0] DEPTH_S = deq_pkg::SUM_W'(deq_pkg::DEPTH);
    localparam deq_pkg::idx_t             LAST_IDX = deq_pkg::IDX_W'(deq_pkg::DEPTH - 1);
    localparam deq_pkg::cnt_t             FULL_CNT = deq_pkg::CNT_W'(deq_pkg::DEPTH);

    deq_pkg::idx_t front_reg, front_next, front_new;
    deq_pkg::cnt_t count_reg, count_next;

    logic                         full;
    logic                         empty;
    deq_pkg::idx_t                front_dec;
    deq_pkg::idx_t                front_inc;
    logic [deq_pkg::SUM_W-1:0]    tail_sum;
    deq_pkg::idx_t                tail_addr;
    logic [deq_pkg::SUM_W-1:0]    back_sum;
    deq_pkg::idx_t                back_addr;
    logic                         wr_en;
    deq_pkg::idx_t                wr_addr;
    logic [deq_pkg::STAT_W-1:0]   status;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;

    // slot just past the back entry
    assign tail_sum  = deq_pkg::SUM_W'(front_reg) + deq_pkg::SUM_W'(count_reg);
    assign tail_addr = (tail_sum >= DEPTH_S) ? deq_pkg::IDX_W'(tail_sum - DEPTH_S)
                                             : deq_pkg::IDX_W'(tail_sum);

    always_comb
    begin
        front_new  = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_addr;
        status     = deq_pkg::ST_OK;
        case (cmd)
            deq_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    front_new  = front_dec;
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                end
            end
            deq_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status = deq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    front_new  = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                front_new = front_reg;
            end
        endcase
    end

    // an empty queue parks its front at slot zero
    assign front_next = (count_next == '0) ? '0 : front_new;

    // back entry of the updated queue; meaningless when empty
    assign back_sum  = deq_pkg::SUM_W'(front_next) + deq_pkg::SUM_W'(count_next)
                       - deq_pkg::SUM_W'(1);
    assign back_addr = (back_sum >= DEPTH_S) ? deq_pkg::IDX_W'(back_sum - DEPTH_S)
                                             : deq_pkg::IDX_W'(back_sum);

    // fields in declaration order of deq_op_t
    assign op = {wr_en, wr_addr, value, front_next, back_addr, status, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/deq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_mem
// slot storage: one write port, two registered read ports, with a bypass
// for a read of the slot written in the same cycle
// ----------------------------------------------------------------------------
module deq_mem
(
    input  logic                               clk,
    input  logic                               en,
    input  deq_pkg::deq_op_t                   op,
    output logic signed [deq_pkg::DATA_W-1:0]  front_data,
    output logic signed [deq_pkg::DATA_W-1:0]  back_data
);

    logic signed [deq_pkg::DATA_W-1:0] slots [deq_pkg::DEPTH];
    logic                              wr;

    assign wr = en && op.wr_en;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots[op.wr_addr] <= op.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_data <= (wr && (op.wr_addr == op.rd_front)) ? op.wr_data
                                                              : slots[op.rd_front];
            back_data  <= (wr && (op.wr_addr == op.rd_back)) ? op.wr_data
                                                             : slots[op.rd_back];
        end
    end

endmodule

// File: sv/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// deque of signed 32-bit values in a circular slot memory with front index
// and entry count; every command returns one status and end-value report
// ----------------------------------------------------------------------------
//
//  channel  dir   handshake     payload
//  -------  ----  ------------  ---------------------------------------------
//  req      sink  valid/ready   cmd[2:0], value[31:0] signed
//  rsp      src   valid/ready   status[1:0], front_value, back_value,
//                               is_empty, occupancy[4:0]
//
//  a command runs in order: the accept cycle updates the pointers, writes
//  the pushed slot and launches both end reads; the load state then takes the
//  registered read data of the slot memory into the result register once that
//  register is free or being emptied; req is ready again only once the result
//  is loaded, so no new command is taken before the last one is through; a
//  stalled rsp holds the next command's read data until the result register frees
//  reset clears pointers, count and handshake state; slot contents are not
//  cleared since only occupied slots are ever reported
//
module double_ended_queue
(
    input  logic       clk,
    input  logic       rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    logic state_reg, state_next;

    logic                              accept;
    logic                              load;
    deq_pkg::deq_op_t                  op;
    logic signed [deq_pkg::DATA_W-1:0] front_data;
    logic signed [deq_pkg::DATA_W-1:0] back_data;

    // command results waiting for the read data
    logic [deq_pkg::STAT_W-1:0] pend_status_reg;
    deq_pkg::cnt_t              pend_count_reg;

    // result register
    logic                              rsp_valid_reg;
    logic [deq_pkg::STAT_W-1:0]        status_reg;
    logic signed [deq_pkg::DATA_W-1:0] front_reg;
    logic signed [deq_pkg::DATA_W-1:0] back_reg;
    logic                              empty_reg;
    logic [deq_pkg::OCC_W-1:0]         occ_reg;

    logic pend_empty;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    // result register is free or being emptied this cycle
    assign load      = (state_reg == ST_LOAD) && (!rsp_valid_reg || rsp.ready);
    assign pend_empty = (pend_count_reg == '0);

    deq_ptr u_ptr
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (accept),
        .cmd   (req.cmd),
        .value (req.value),
        .op    (op)
    );

    deq_mem u_mem
    (
        .clk        (clk),
        .en         (accept),
        .op         (op),
        .front_data (front_data),
        .back_data  (back_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= op.status;
            pend_count_reg  <= op.count;
        end
        if (load)
        begin
            status_reg <= pend_status_reg;
            // an empty queue reports zero at both ends
            front_reg  <= pend_empty ? '0 : front_data;
            back_reg   <= pend_empty ? '0 : back_data;
            empty_reg  <= pend_empty;
            occ_reg    <= deq_pkg::OCC_W'(pend_count_reg);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.front_value = front_reg;
    assign rsp.back_value  = back_reg;
    assign rsp.is_empty    = empty_reg;
    assign rsp.occupancy   = occ_reg;

endmodule

// File: bench/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// watches the command and result channels of the deque, keeps its own
// circular-buffer copy of the queue and compares every result word
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    deq_req_if   req,
    deq_rsp_if   rsp,
    output int   errors,
    output int   outstanding
);

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
    } deq_report_t;

    logic signed [DATA_W-1:0] shadow_slots [DEPTH];
    int                       head;
    int                       fill;
    deq_report_t              expected_reports [$];
    deq_report_t              new_report;
    deq_report_t              oldest_report;

    // one command applied to the shadow queue, returns the report it should give
    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [DATA_W-1:0] value,
                                 output deq_report_t rep);
        rep = '0;
        rep.status = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT:
                if (fill >= DEPTH)
                    rep.status = ST_OVERFLOW;
                else
                begin
                    head = (head == 0) ? DEPTH - 1 : head - 1;
                    shadow_slots[head] = value;
                    fill++;
                end
            CMD_PUSH_BACK:
                if (fill >= DEPTH)
                    rep.status = ST_OVERFLOW;
                else
                begin
                    shadow_slots[(head + fill) % DEPTH] = value;
                    fill++;
                end
            CMD_POP_FRONT:
                if (fill == 0)
                    rep.status = ST_UNDERFLOW;
                else
                begin
                    head = (head + 1) % DEPTH;
                    fill--;
                end
            CMD_POP_BACK:
                if (fill == 0)
                    rep.status = ST_UNDERFLOW;
                else
                    fill--;
            default: ;
        endcase
        // front index snaps back to zero whenever the queue drains
        if (fill == 0)
            head = 0;
        else
        begin
            rep.front_value = shadow_slots[head];
            rep.back_value  = shadow_slots[(head + fill - 1) % DEPTH];
        end
        rep.is_empty  = (fill == 0);
        rep.occupancy = fill[OCC_W-1:0];
    endtask

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reports.delete();
            head        = 0;
            fill        = 0;
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            // new command first, so a result in the same cycle still meets the oldest entry
            if (req.valid && req.ready)
            begin
                apply_command(req.cmd, req.value, new_report);
                expected_reports.push_back(new_report);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected, status %h occupancy %0d",
                             $time, rsp.status, rsp.occupancy);
                end
                else
                begin
                    oldest_report = expected_reports.pop_front();
                    check_field("status", DATA_W'(oldest_report.status),
                                DATA_W'(rsp.status));
                    check_field("front_value", oldest_report.front_value, rsp.front_value);
                    check_field("back_value", oldest_report.back_value, rsp.back_value);
                    check_field("is_empty", DATA_W'(oldest_report.is_empty),
                                DATA_W'(rsp.is_empty));
                    check_field("occupancy", DATA_W'(oldest_report.occupancy),
                                DATA_W'(rsp.occupancy));
                end
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the double-ended queue: a directed opening over
// empty and full corners, then random command streams that drift between
// filling and draining, under three sender/receiver stall mixes
// ----------------------------------------------------------------------------
module tb;

    import deq_pkg::*;

    // codes 5..7 have no meaning and must behave as a peek
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam int               UNUSED_SPAN      = 2;

    // far above the slowest legal run (about 1400 words)
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_WORDS  = 470;
    localparam int DRIFT_RUN    = 40;
    localparam int TAIL_CYCLES  = 8;

    logic clk;
    logic rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    int err_count;
    int pending;
    int cycle_count;

    // idle odds, in percent per cycle, changed per phase
    int snd_idle_pct;
    int rcv_idle_pct;

    double_ended_queue dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deq_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .errors      (err_count),
        .outstanding (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost result word ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver side: ready drops at random with the current odds
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // one command word; entered and left at a falling edge
    // valid stays high into the next word unless an idle cycle is drawn
    task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= c;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // sender holds off until every result word is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // push values lean on the sign boundary and the all-zero / all-one patterns
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // push_pct steers the queue toward full or empty so both ends get hit often
    function automatic logic [CMD_W-1:0] pick_command(input int push_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return CMD_W'(CMD_UNUSED_FIRST + $urandom_range(UNUSED_SPAN));
        if (roll < 6)
            return CMD_PEEK;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    task automatic random_phase(input int words);
        int push_pct;
        for (int i = 0; i < words; i++)
        begin
            // new drift every run: mostly filling, mostly draining, or balanced
            if (i % DRIFT_RUN == 0)
            begin
                case ($urandom_range(2))
                    0:       push_pct = 75;
                    1:       push_pct = 25;
                    default: push_pct = 50;
                endcase
            end
            send_word(pick_command(push_pct), pick_value());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_PEEK;
        req_ch.value = '0;
        snd_idle_pct = 17;
        rcv_idle_pct = 55;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // underflow at both ends, and an unused code, on the empty queue
        send_word(CMD_POP_FRONT, 32'sh7fff_ffff);
        send_word(CMD_POP_BACK, 32'sh8000_0000);
        send_word(CMD_W'(CMD_UNUSED_FIRST + UNUSED_SPAN), '1);
        // push front from index zero wraps to the top slot
        send_word(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        send_word(CMD_PUSH_BACK, 32'sh8000_0000);
        send_word(CMD_UNUSED_FIRST, '0);
        send_word(CMD_W'(CMD_UNUSED_FIRST + 1), 32'sh5a5a_a5a5);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_FRONT, '0);
        // fill from both ends, then overflow at both ends
        for (int i = 0; i < DEPTH; i++)
            send_word(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        send_word(CMD_PUSH_FRONT, '1);
        send_word(CMD_PUSH_BACK, '0);
        drain_results();

        // random stream under slow receiver, slow sender, then full speed
        random_phase(PHASE_WORDS);
        drain_results();
        snd_idle_pct = 55;
        rcv_idle_pct = 17;
        random_phase(PHASE_WORDS);
        drain_results();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_phase(PHASE_WORDS);

        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
